@@ design/pfc_pkg.sv @@
package pfc_pkg;

  localparam int NumCells   = 25;
  localparam int NumLetters = 26;

  localparam logic [2:0] ModeKeyStart = 3'd0;
  localparam logic [2:0] ModeKeyByte  = 3'd1;
  localparam logic [2:0] ModeKeyEnd   = 3'd2;
  localparam logic [2:0] ModeText     = 3'd3;
  localparam logic [2:0] ModeTextEnd  = 3'd4;

  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterX = 5'd23;

  localparam logic [6:0] AsciiUpperA = 7'h41;
  localparam logic [6:0] AsciiUpperZ = 7'h5a;

  typedef struct packed {
    logic accept;
    logic pos_rd_b;
    logic cap_pa;
    logic cap_pb;
    logic sq_rd_x;
    logic cap_x;
    logic cap_y;
    logic fill_step;
    logic push_x;
    logic push_y;
  } pfc_cmd_t;

  typedef struct packed {
    logic pair_go;
    logic fill_go;
    logic fill_last;
    logic out_free;
  } pfc_sts_t;

endpackage

@@ design/pfc_ram.sv @@
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pfc_ctrl.sv @@
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pfc_sts_t sts_i,
  output pfc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StFill,
    StPosA,
    StPosB,
    StCell,
    StSqX,
    StSqY,
    StEmitX,
    StEmitY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.fill_go) begin
            state_d = StFill;
          end else if (sts_i.pair_go) begin
            state_d = StPosA;
          end
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = StIdle;
        end
      end
      StPosA: state_d = StPosB;
      StPosB: begin
        cmd_o.pos_rd_b = 1'b1;
        cmd_o.cap_pa   = 1'b1;
        state_d        = StCell;
      end
      StCell: begin
        cmd_o.cap_pb = 1'b1;
        state_d      = StSqX;
      end
      StSqX: begin
        cmd_o.sq_rd_x = 1'b1;
        state_d       = StSqY;
      end
      StSqY: begin
        cmd_o.cap_x = 1'b1;
        state_d     = StEmitX;
      end
      StEmitX: begin
        cmd_o.cap_y = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.push_x = 1'b1;
          state_d      = StEmitY;
        end
      end
      StEmitY: begin
        if (sts_i.out_free) begin
          cmd_o.push_y = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/pfc_dp.sv @@
module pfc_dp
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pfc_cmd_t   cmd_i,
  output pfc_sts_t   sts_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [6:0] out_char_o,
  output logic       pair_last_o
);

  // {valid, index}, case folded, J mapped to I
  function automatic logic [5:0] letter_of(input logic [7:0] b);
    logic [7:0] u;
    logic [4:0] l;
    u = (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
    l = 5'(u - 8'h41);
    if (l == LetterJ) begin
      l = LetterI;
    end
    return {(u >= 8'h41 && u <= 8'h5a), l};
  endfunction

  function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] d;
    d = p - cell_idx(row_of(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic logic [2:0] add_mod5(input logic [2:0] x, input logic [2:0] s);
    logic [3:0] t;
    t = {1'b0, x} + {1'b0, s};
    return (t >= 4'd5) ? 3'(t - 4'd5) : t[2:0];
  endfunction

  logic                  dir_q;
  logic [NumLetters-1:0] used_q;
  logic [4:0]            fill_cnt_q;
  logic [4:0]            fill_idx_q;
  logic [4:0]            held_q;
  logic                  held_v_q;
  logic                  out_valid_q;
  logic [6:0]            out_char_q;
  logic                  pair_last_q;
  logic [4:0]            a_q, b_q, pa_q, pb_q;
  logic [4:0]            y_idx_q;
  logic                  x_ok_q, y_ok_q;
  logic [4:0]            x_q, y_q;

  logic [5:0] in_let;
  logic       in_lv;
  logic [4:0] in_l;
  logic       text_hit, end_hit, key_clear, key_byte, fill_req;
  logic [4:0] place_l;
  logic       place_en;
  logic [4:0] pos_raddr, pos_rdata, sq_raddr, sq_rdata;
  logic [2:0] r1, c1, r2, c2, sh;
  logic [4:0] x_idx, y_idx;

  assign in_let = letter_of(data_byte_i);
  assign in_lv  = in_let[5];
  assign in_l   = in_let[4:0];

  assign key_clear = cmd_i.accept && mode_i == ModeKeyStart;
  assign key_byte  = cmd_i.accept && mode_i == ModeKeyByte && in_lv;
  assign text_hit  = cmd_i.accept && mode_i == ModeText && in_lv;
  assign end_hit   = cmd_i.accept && mode_i == ModeTextEnd && held_v_q;
  assign fill_req  = cmd_i.fill_step && fill_idx_q != LetterJ;
  assign place_l   = cmd_i.fill_step ? fill_idx_q : in_l;
  assign place_en  = (key_byte || fill_req) && !used_q[place_l]
                     && fill_cnt_q < 5'(NumCells);

  assign sts_o.pair_go   = held_v_q && ((mode_i == ModeText && in_lv)
                                        || mode_i == ModeTextEnd);
  assign sts_o.fill_go   = mode_i == ModeKeyEnd;
  assign sts_o.fill_last = fill_idx_q == 5'(NumLetters - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  pfc_ram #(.WIDTH(5), .DEPTH(NumCells)) u_square (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (fill_cnt_q),
    .wdata_i (place_l),
    .raddr_i (sq_raddr),
    .rdata_o (sq_rdata)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(NumLetters)) u_position (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (place_l),
    .wdata_i (fill_cnt_q),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign pos_raddr = cmd_i.pos_rd_b ? b_q : a_q;

  assign r1 = row_of(pa_q);
  assign c1 = col_of(pa_q);
  assign r2 = row_of(pb_q);
  assign c2 = col_of(pb_q);
  assign sh = dir_q ? 3'd4 : 3'd1;

  always_comb begin
    if (r1 == r2) begin
      x_idx = cell_idx(r1, add_mod5(c1, sh));
      y_idx = cell_idx(r2, add_mod5(c2, sh));
    end else if (c1 == c2) begin
      x_idx = cell_idx(add_mod5(r1, sh), c1);
      y_idx = cell_idx(add_mod5(r2, sh), c2);
    end else begin
      x_idx = cell_idx(r1, c2);
      y_idx = cell_idx(r2, c1);
    end
  end

  assign sq_raddr = cmd_i.sq_rd_x ? x_idx : y_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      used_q      <= '0;
      fill_cnt_q  <= '0;
      fill_idx_q  <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (key_clear) begin
        used_q     <= '0;
        fill_cnt_q <= '0;
      end else if (place_en) begin
        used_q[place_l] <= 1'b1;
        fill_cnt_q      <= fill_cnt_q + 5'd1;
      end
      if (cmd_i.accept && sts_o.fill_go) begin
        fill_idx_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_idx_q <= fill_idx_q + 5'd1;
      end
      if (text_hit) begin
        if (!held_v_q) begin
          held_v_q <= 1'b1;
        end else if (in_l != held_q) begin
          held_v_q <= 1'b0;
        end
      end else if (end_hit) begin
        held_v_q <= 1'b0;
      end
      if (cmd_i.push_x || cmd_i.push_y) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_hit && !held_v_q) begin
      held_q <= in_l;
    end
    if (text_hit && held_v_q) begin
      a_q <= held_q;
      b_q <= (in_l == held_q) ? LetterX : in_l;
    end else if (end_hit) begin
      a_q <= held_q;
      b_q <= LetterX;
    end
    if (cmd_i.cap_pa) begin
      pa_q <= used_q[a_q] ? pos_rdata : '0;
    end
    if (cmd_i.cap_pb) begin
      pb_q <= used_q[b_q] ? pos_rdata : '0;
    end
    if (cmd_i.sq_rd_x) begin
      y_idx_q <= y_idx;
      x_ok_q  <= x_idx < fill_cnt_q;
      y_ok_q  <= y_idx < fill_cnt_q;
    end
    if (cmd_i.cap_x) begin
      x_q <= x_ok_q ? sq_rdata : '0;
    end
    if (cmd_i.cap_y) begin
      y_q <= y_ok_q ? sq_rdata : '0;
    end
    if (cmd_i.push_x) begin
      out_char_q  <= AsciiUpperA + {2'b00, x_q};
      pair_last_q <= 1'b0;
    end else if (cmd_i.push_y) begin
      out_char_q  <= AsciiUpperA + {2'b00, y_q};
      pair_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign pair_last_o = pair_last_q;

endmodule

@@ design/playfair_cipher_engine_unit.sv @@
// Playfair cipher engine over a 5x5 key square, one input transaction at a
// time. Key start, key byte, ignored bytes and a text letter that does not
// complete a pair are handled in the idle state. Key end runs the fill
// sequencer over every alphabet letter. A transaction that completes a pair
// (including text end with a held letter) runs the accept, two reads of the
// position memory, an index step, two reads of the key-square memory, and
// two output pushes that wait out any output stall, all through the single
// read port of each memory. Results leave through a one-entry output
// register; direction may be written only while the engine is idle.
module playfair_cipher_engine_unit
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       pair_last_o
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .pair_last_o (pair_last_o)
  );

  a_one_activity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.push_x, cmd.push_y, in_ready_o, cmd.fill_step}))
    else $error("overlapping controller activity");

  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_x |=> out_valid_o && !pair_last_o)
    else $error("first letter of pair not presented");

  a_second_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_y |=> out_valid_o && pair_last_o)
    else $error("second letter of pair not presented");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_char_o >= AsciiUpperA && out_char_o <= AsciiUpperZ)
    else $error("output is not an uppercase letter");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  localparam int          CycleLimit   = 400000;
  localparam int          SettleCycles = 40;
  localparam int          HoldCycles   = 400;
  localparam logic [2:0]  ModeSpare    = 3'd5;
  localparam logic [2:0]  ModeLastCode = 3'd7;
  localparam logic [7:0]  LowerA       = 8'h61;
  localparam logic [7:0]  LowerZ       = 8'h7a;
  localparam logic [7:0]  CaseBit      = 8'h20;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } cipher_char_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [2:0] mode_i      = ModeKeyStart;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [6:0] out_char_o;
  logic       pair_last_o;

  // predictor state
  logic [4:0]   square_letter [NumCells];
  logic [4:0]   letter_cell   [NumLetters];
  bit           letter_placed [NumLetters];
  int unsigned  fill_cells   = 0;
  logic [4:0]   held_letter  = '0;
  bit           held_valid   = 1'b0;
  bit           decrypt_mode = 1'b0;

  cipher_char_t pending_chars [$];
  int           mismatch_count  = 0;
  int           cycle_count     = 0;
  int           text_items_sent = 0;
  int           send_idle_pct   = 0;
  int           ready_stall_pct = 0;
  int           hold_req        = 0;
  logic [7:0]   prev_text       = 8'h41;

  playfair_cipher_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .pair_last_o (pair_last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int fold_letter(logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (v >= LowerA && v <= LowerZ) v = v - CaseBit;
    if (v < {1'b0, AsciiUpperA} || v > {1'b0, AsciiUpperZ}) return -1;
    v = v - {1'b0, AsciiUpperA};
    if (v[4:0] == LetterJ) return int'(LetterI);
    return int'(v);
  endfunction

  function automatic void place_letter(int l);
    if (letter_placed[l] || fill_cells >= NumCells) return;
    square_letter[fill_cells] = l[4:0];
    letter_cell[l]            = fill_cells[4:0];
    letter_placed[l]          = 1'b1;
    fill_cells++;
  endfunction

  function automatic int unsigned cell_of(logic [4:0] l);
    if (!letter_placed[l]) return 0;
    return letter_cell[l];
  endfunction

  function automatic int unsigned letter_at(int unsigned r, int unsigned c);
    int unsigned idx;
    idx = (r % 5) * 5 + (c % 5);
    if (idx >= fill_cells) return 0;
    return square_letter[idx];
  endfunction

  function automatic void push_cipher_pair(logic [4:0] a, logic [4:0] b);
    int unsigned pa, pb, r1, c1, r2, c2, sh, x, y;
    cipher_char_t cc;
    pa = cell_of(a);
    pb = cell_of(b);
    r1 = pa / 5;
    c1 = pa % 5;
    r2 = pb / 5;
    c2 = pb % 5;
    sh = decrypt_mode ? 4 : 1;
    if (r1 == r2) begin
      x = letter_at(r1, c1 + sh);
      y = letter_at(r2, c2 + sh);
    end else if (c1 == c2) begin
      x = letter_at(r1 + sh, c1);
      y = letter_at(r2 + sh, c2);
    end else begin
      x = letter_at(r1, c2);
      y = letter_at(r2, c1);
    end
    cc.ch   = AsciiUpperA + x[6:0];
    cc.last = 1'b0;
    pending_chars.push_back(cc);
    cc.ch   = AsciiUpperA + y[6:0];
    cc.last = 1'b1;
    pending_chars.push_back(cc);
  endfunction

  function automatic void cipher_predict(logic [2:0] m, logic [7:0] d);
    int l;
    l = fold_letter(d);
    case (m)
      ModeKeyStart: begin
        foreach (letter_placed[i]) letter_placed[i] = 1'b0;
        fill_cells = 0;
      end
      ModeKeyByte: begin
        if (l >= 0) place_letter(l);
      end
      ModeKeyEnd: begin
        for (int i = 0; i < NumLetters; i++)
          if (i != LetterJ) place_letter(i);
      end
      ModeText: begin
        if (l >= 0) begin
          if (!held_valid) begin
            held_letter = l[4:0];
            held_valid  = 1'b1;
          end else if (l[4:0] == held_letter) begin
            // second copy of a doubled letter starts the next pair
            push_cipher_pair(held_letter, LetterX);
          end else begin
            held_valid = 1'b0;
            push_cipher_pair(held_letter, l[4:0]);
          end
        end
      end
      ModeTextEnd: begin
        if (held_valid) begin
          held_valid = 1'b0;
          push_cipher_pair(held_letter, LetterX);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] m, input logic [7:0] d);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (m <= ModeTextEnd) text_items_sent++;
    cipher_predict(m, d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic new_phase(input bit dir, input int send_pct, input int stall_pct);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    decrypt_mode    = dir;
    send_idle_pct   = send_pct;
    ready_stall_pct = stall_pct;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = {1'b0, AsciiUpperA} + 8'($urandom_range(25));
    if ($urandom_range(1)) c = c | CaseBit;
    return c;
  endfunction

  function automatic logic [7:0] key_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return rand_letter();
    if (pick < 80) return {1'b0, AsciiUpperA} + LetterJ + ($urandom_range(1) ? CaseBit : 8'h00);
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return prev_text;
    if (pick < 22) return {1'b0, AsciiUpperA} + LetterX;
    if (pick < 85) prev_text = rand_letter();
    else return 8'($urandom_range(255));
    return prev_text;
  endfunction

  task automatic send_session();
    int n;
    if ($urandom_range(99) < 90) send_item(ModeKeyStart, 8'($urandom_range(255)));
    n = $urandom_range(14);
    repeat (n) send_item(ModeKeyByte, key_byte());
    if ($urandom_range(99) < 85) send_item(ModeKeyEnd, 8'($urandom_range(255)));
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(ModeKeyByte, key_byte());
    end
    n = $urandom_range(2, 30);
    repeat (n) send_item(ModeText, text_byte());
    if ($urandom_range(99) < 70) send_item(ModeTextEnd, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_item(3'($urandom_range(ModeLastCode)), 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int n_items);
    int target;
    target = text_items_sent + n_items;
    while (text_items_sent < target) begin
      if ($urandom_range(99) < 80) send_session();
      else send_noise();
    end
  endtask

  // corner cases: empty square, held letter over a key start, doubled X,
  // full square, J folding, empty text end, unused modes
  task automatic test_directed_cases();
    new_phase(1'b0, 0, 0);
    send_item(ModeText, "h");
    send_item(ModeText, "i");
    send_item(ModeTextEnd, 8'h00);
    send_item(ModeText, "Q");
    send_item(ModeKeyStart, 8'hff);
    send_item(ModeKeyByte, "p");
    send_item(ModeKeyByte, "L");
    send_item(ModeKeyByte, "a");
    send_item(ModeKeyByte, "y");
    send_item(ModeKeyByte, "j");
    send_item(ModeKeyByte, "1");
    send_item(ModeKeyByte, 8'hff);
    send_item(ModeKeyEnd, 8'h00);
    send_item(ModeKeyByte, "Z");
    send_item(ModeText, "x");
    send_item(ModeText, "X");
    send_item(ModeText, "X");
    send_item(ModeText, "!");
    send_item(ModeText, 8'h00);
    send_item(ModeTextEnd, 8'hff);
    send_item(ModeText, "J");
    send_item(ModeText, "i");
    send_item(ModeTextEnd, 8'h00);
    send_item(ModeSpare, "A");
    send_item(ModeLastCode, "B");
  endtask

  task automatic test_no_idle();
    new_phase(1'b1, 0, 0);
    run_random(300);
  endtask

  task automatic test_sender_idle();
    new_phase(1'b0, 87, 0);
    run_random(220);
  endtask

  task automatic test_receiver_stall();
    new_phase(1'b1, 0, 87);
    run_random(220);
  endtask

  task automatic test_both_idle();
    new_phase(1'b0, 9, 9);
    run_random(260);
  endtask

  // long output hold-off fills the block, then the sender waits for a full drain
  task automatic test_backpressure();
    new_phase(1'b1, 0, 0);
    hold_req++;
    run_random(70);
    drain();
    run_random(50);
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  // one output transaction per handshake, checked against the oldest prediction
  always @(posedge clk_i) begin
    cipher_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output char %h last %b", $time, out_char_o, pair_last_o);
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) begin
          mismatch_count++;
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char_o);
        end
        if (pair_last_o !== want.last) begin
          mismatch_count++;
          $display("%0t: pair_last expected %b actual %b", $time, want.last, pair_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d outputs still pending", $time, pending_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/pfc_pkg.sv
design/pfc_ram.sv
design/pfc_ctrl.sv
design/pfc_dp.sv
design/playfair_cipher_engine_unit.sv
tb/sv/testbench.sv
